// File: design/tlfq_pkg.sv
// Shared types and constants for the three-level feedback queue scheduler.
package tlfq_pkg;

  localparam int QueueDepthDef = 16;
  localparam logic [7:0] SliceOneRst = 8'd2;
  localparam logic [7:0] SliceTwoRst = 8'd4;

  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StReject = 2'd1;
  localparam logic [1:0] StTick   = 2'd2;

  localparam logic CfgSliceOne = 1'b0;
  localparam logic CfgSliceTwo = 1'b1;

  // One queued process: id, remaining burst and slice left.
  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] rem;
    logic [7:0]  slice;
  } entry_t;

  // Command from the scheduler to one queue's cell row.
  typedef struct packed {
    logic   push_tail;
    logic   push_head;
    logic   pop;
    entry_t data;
  } qcmd_t;

  function automatic logic [7:0] fix_slice(input logic [7:0] s);
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

endpackage

// File: design/tlfq_cell.sv
// One storage cell of a queue: holds an entry and shifts to either neighbor.
module tlfq_cell
  import tlfq_pkg::*;
(
  input  logic   clk,
  input  logic   shift_dn,  // take the entry of the previous neighbor (toward head)
  input  logic   shift_up,  // take the entry of the next neighbor (toward tail)
  input  logic   load,      // take the new entry
  input  entry_t from_prev,
  input  entry_t from_next,
  input  entry_t new_data,
  output entry_t q
);

  entry_t q_r;

  // Entry update: load wins, else shift in one direction.
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= new_data;
    end else if (shift_dn) begin
      q_r <= from_prev;
    end else if (shift_up) begin
      q_r <= from_next;
    end
  end

  assign q = q_r;

endmodule

// File: design/tlfq_queue.sv
// One queue level built as a row of cells; cell 0 is the head.
module tlfq_queue
  import tlfq_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic   clk,
  input  logic   rst_n,
  input  qcmd_t  cmd,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count_r, count_nxt;
  entry_t          cell_q [Depth];

  // Fill count of the row.
  always_comb begin
    count_nxt = count_r;
    if (cmd.push_tail || cmd.push_head) begin
      count_nxt = count_r + CntW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Row of cells: a head push shifts toward the tail, a pop toward the head.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t prev_d, next_d;
    assign prev_d = (i == 0) ? cmd.data : cell_q[(i == 0) ? 0 : i - 1];
    assign next_d = (i == Depth - 1) ? cell_q[i] : cell_q[(i == Depth - 1) ? i : i + 1];
    tlfq_cell u_cell (
      .clk       (clk),
      .shift_dn  (cmd.push_head),
      .shift_up  (cmd.pop),
      .load      (cmd.push_tail && (count_r == CntW'(i))),
      .from_prev (prev_d),
      .from_next (next_d),
      .new_data  (cmd.data),
      .q         (cell_q[i])
    );
  end

  assign head  = cell_q[0];
  assign empty = (count_r == '0);
  assign full  = (count_r == CntW'(Depth));

endmodule

// File: design/three_level_feedback_queue_scheduler_unit.sv
// Top level of the three-level feedback queue scheduler.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_tvalid/in_tready | tdata {new_burst,new_pid}, tuser mode
//  out_    | output    | out_tvalid/tready   | tdata {preempted..status}
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An arrival result is ready in the cycle after acceptance. A tick passes through the
// steps preempt, select and run, and skips run when there is nothing to run.
// Each step issues at most one command to a queue row. The result sits in an output
// register and a new item is taken only once it has been taken, so no item is accepted
// before the last one is through. Reset is synchronous and needs no clearing pass.
module three_level_feedback_queue_scheduler_unit
  import tlfq_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // new_pid [7:0], new_burst [23:8]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, run_pid, run_level, finished, demoted,
                                  // preempted, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_PRE, S_SEL, S_RUN} state_t;

  state_t     state_r;
  logic [7:0] slice1_r, slice2_r;
  logic       run_v_r;
  entry_t     run_e_r;
  logic [1:0] run_lvl_r;
  logic       mode_r, pre_r;
  entry_t     new_r;
  logic       out_v_r;
  logic [15:0] out_d_r;

  qcmd_t  cmd [3];
  entry_t hd [3];
  logic   emp [3], ful [3];

  for (genvar k = 0; k < 3; k++) begin : g_q
    tlfq_queue #(.Depth(QueueDepth)) u_q (
      .clk (clk), .rst_n (rst_n), .cmd (cmd[k]),
      .head (hd[k]), .empty (emp[k]), .full (ful[k])
    );
  end

  assign in_tready  = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // Decisions of the current step.
  logic       pre_go, sel_any, fin, expired, dem_go;
  logic [1:0] sel_k;
  entry_t     sel_e, dem_e;
  always_comb begin
    pre_go = run_v_r && ((run_lvl_r == 2'd2 && !emp[0]) ||
             (run_lvl_r == 2'd3 && (!emp[0] || !emp[1]))) &&
             !ful[(run_lvl_r == 2'd3) ? 2 : 1];
    sel_any = !emp[0] || !emp[1] || !emp[2];
    sel_k   = !emp[0] ? 2'd0 : (!emp[1] ? 2'd1 : 2'd2);
    sel_e   = hd[sel_k];
    if (sel_k == 2'd0) begin
      sel_e.slice = fix_slice(slice1_r);
    end
    fin     = run_e_r.rem <= 16'd1;
    expired = (run_lvl_r != 2'd3) && (run_e_r.slice <= 8'd1);
    dem_e   = run_e_r;
    dem_e.rem   = run_e_r.rem - 16'd1;
    dem_e.slice = (run_lvl_r == 2'd1) ? fix_slice(slice2_r) : 8'd0;
    dem_go  = !fin && expired && !ful[(run_lvl_r == 2'd1) ? 1 : 2];
    for (int k = 0; k < 3; k++) begin
      cmd[k] = '0;
    end
    case (state_r)
      S_IDLE: begin
        cmd[0].push_tail = in_tvalid && in_tready && !in_tuser && !ful[0];
        cmd[0].data      = '{pid: in_tdata[7:0], rem: in_tdata[23:8], slice: 8'd0};
      end
      S_PRE: begin
        if (pre_go) begin
          cmd[run_lvl_r - 2'd1].push_head = 1'b1;
          cmd[run_lvl_r - 2'd1].data      = run_e_r;
        end
      end
      S_SEL: begin
        if (!run_v_r && sel_any) begin
          cmd[sel_k].pop = 1'b1;
        end
      end
      S_RUN: begin
        if (dem_go) begin
          cmd[run_lvl_r].push_tail = 1'b1;
          cmd[run_lvl_r].data      = dem_e;
        end
      end
      default: ;
    endcase
  end

  // Sequencer with running-process and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      slice1_r  <= SliceOneRst;
      slice2_r  <= SliceTwoRst;
      run_v_r   <= 1'b0;
      run_lvl_r <= 2'd0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CfgSliceOne) slice1_r <= cfg_data;
        else slice2_r <= cfg_data;
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            if (!in_tuser) begin
              out_v_r <= 1'b1;
              out_d_r <= {14'd0, ful[0] ? StReject : StAccept};
            end else begin
              state_r <= S_PRE;
            end
          end
        end
        S_PRE: begin
          pre_r <= pre_go;
          if (pre_go) run_v_r <= 1'b0;
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (!run_v_r && sel_any) begin
            run_v_r   <= 1'b1;
            run_e_r   <= sel_e;
            run_lvl_r <= sel_k + 2'd1;
            state_r   <= S_RUN;
          end else if (run_v_r) begin
            state_r <= S_RUN;
          end else begin
            out_v_r <= 1'b1;
            out_d_r <= {1'b0, pre_r, 12'd0, StTick};
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          out_v_r <= 1'b1;
          out_d_r <= {1'b0, pre_r, dem_go, fin, run_lvl_r, run_e_r.pid, StTick};
          if (fin) begin
            run_v_r <= 1'b0;
            run_e_r.rem <= 16'd0;
          end else begin
            run_e_r.rem <= run_e_r.rem - 16'd1;
            if (run_lvl_r != 2'd3) begin
              if (!expired) run_e_r.slice <= run_e_r.slice - 8'd1;
              else if (dem_go) run_v_r <= 1'b0;
              else run_e_r.slice <= (run_lvl_r == 2'd1) ? fix_slice(slice1_r)
                                                        : fix_slice(slice2_r);
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
